>>> hw/rtl/rpcf_pkg.sv
// ----------------------------------------------------------------------------
// rpcf_pkg
// shared types, codes and fixed-point constants of the rgb pixel color filter
// ----------------------------------------------------------------------------
package rpcf_pkg;

   localparam int CHAN_W         = 8;
   localparam int GAIN_W         = 16;
   localparam int GAIN_FRAC_BITS = 8;

   // luma weights in q0.16, they sum to one
   localparam int LUMA_FRAC_BITS = 16;
   localparam int LUMA_COEF_W    = 16;
   localparam logic [LUMA_COEF_W-1:0] LUMA_W_RED   = 16'd13933;
   localparam logic [LUMA_COEF_W-1:0] LUMA_W_GREEN = 16'd46871;
   localparam logic [LUMA_COEF_W-1:0] LUMA_W_BLUE  = 16'd4732;

   localparam int PROD_W       = CHAN_W + GAIN_W;
   localparam int LUMA_SUM_W   = PROD_W + 2;
   localparam int GAIN_SHIFT_W = PROD_W - GAIN_FRAC_BITS;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INVERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GAIN   = 2'd2;

   // register file, one 32-bit word per register
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;
   localparam int DATA_W    = 32;
   localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DEPTH      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_RED   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_GREEN = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_BLUE  = 3'd4;

   localparam logic [CHAN_W-1:0] DEPTH_RESET = 8'd255;
   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_data_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } rsp_data_type;

endpackage

>>> hw/rtl/rgb_pixel_color_filter.sv
// ----------------------------------------------------------------------------
// rgb_pixel_color_filter
// per-pixel rgb filter: bt.709 grayscale, invert, or per-channel gain
// ----------------------------------------------------------------------------
// one pixel in and one pixel out per transfer, one pixel per clock sustained
// while rsp_stall is low. a pixel passes three registered stages in order:
// stage 1 does the six 8x16 products (luma weights and gains), stage 2 sums
// the luma and shifts and saturates the gained channels, stage 3 picks the
// result by mode and also forms the inverted channels. each stage has its
// own valid bit and moves on whenever the stage ahead is empty or empties
// in the same cycle, so the input keeps taking pixels while a result waits
// on rsp_stall; req_stall rises only when all three stages are full and the
// output is stalled. the block holds no state between pixels. registers:
// mode at 0x00 (0 gray, 1 invert, 2 gain, 3 pass through), depth at 0x04,
// gain_red/green/blue at 0x08/0x0c/0x10 in unsigned q8.8. write them only
// while no pixel is in flight.
module rgb_pixel_color_filter
   import rpcf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // pixel input
   input  logic                req_valid,
   output logic                req_stall,
   input  req_data_type        req_data,
   // pixel output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_data_type        rsp_data,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   // ------------------------------------------------------------------------
   // register file
   // ------------------------------------------------------------------------
   logic [MODE_W-1:0]    mode_ff;
   logic [CHAN_W-1:0]    depth_ff;
   logic [GAIN_W-1:0]    gain_red_ff;
   logic [GAIN_W-1:0]    gain_green_ff;
   logic [GAIN_W-1:0]    gain_blue_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 reg_write;

   // word address, low byte bits ignored
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign reg_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_GRAY;
         depth_ff      <= DEPTH_RESET;
         gain_red_ff   <= GAIN_RESET;
         gain_green_ff <= GAIN_RESET;
         gain_blue_ff  <= GAIN_RESET;
      end else if (reg_write) begin
         case (reg_idx)
            REG_MODE:       mode_ff       <= pwdata[MODE_W-1:0];
            REG_DEPTH:      depth_ff      <= pwdata[CHAN_W-1:0];
            REG_GAIN_RED:   gain_red_ff   <= pwdata[GAIN_W-1:0];
            REG_GAIN_GREEN: gain_green_ff <= pwdata[GAIN_W-1:0];
            REG_GAIN_BLUE:  gain_blue_ff  <= pwdata[GAIN_W-1:0];
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:       prdata = DATA_W'(mode_ff);
         REG_DEPTH:      prdata = DATA_W'(depth_ff);
         REG_GAIN_RED:   prdata = DATA_W'(gain_red_ff);
         REG_GAIN_GREEN: prdata = DATA_W'(gain_green_ff);
         REG_GAIN_BLUE:  prdata = DATA_W'(gain_blue_ff);
         default:        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // pipeline flow control
   // ------------------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic s1_ready;
   logic s2_ready;
   logic s3_ready;
   logic req_xfer;

   // a stage takes new data when empty or when its content moves on
   assign s3_ready  = ~rsp_valid_ff | ~rsp_stall;
   assign s2_ready  = ~s2_valid_ff | s3_ready;
   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign req_stall = ~s1_ready;
   assign req_xfer  = req_valid & s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff  <= req_valid;
         if (s2_ready) s2_valid_ff  <= s1_valid_ff;
         if (s3_ready) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: products
   // ------------------------------------------------------------------------
   req_data_type      s1_pix_ff;
   logic [PROD_W-1:0] s1_luma_red_ff,  s1_luma_green_ff,  s1_luma_blue_ff;
   logic [PROD_W-1:0] s1_gain_red_ff,  s1_gain_green_ff,  s1_gain_blue_ff;
   logic [PROD_W-1:0] s1_luma_red_in,  s1_luma_green_in,  s1_luma_blue_in;
   logic [PROD_W-1:0] s1_gain_red_in,  s1_gain_green_in,  s1_gain_blue_in;

   assign s1_luma_red_in   = PROD_W'(req_data.red_in)   * PROD_W'(LUMA_W_RED);
   assign s1_luma_green_in = PROD_W'(req_data.green_in) * PROD_W'(LUMA_W_GREEN);
   assign s1_luma_blue_in  = PROD_W'(req_data.blue_in)  * PROD_W'(LUMA_W_BLUE);
   assign s1_gain_red_in   = PROD_W'(req_data.red_in)   * PROD_W'(gain_red_ff);
   assign s1_gain_green_in = PROD_W'(req_data.green_in) * PROD_W'(gain_green_ff);
   assign s1_gain_blue_in  = PROD_W'(req_data.blue_in)  * PROD_W'(gain_blue_ff);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pix_ff        <= req_data;
         s1_luma_red_ff   <= s1_luma_red_in;
         s1_luma_green_ff <= s1_luma_green_in;
         s1_luma_blue_ff  <= s1_luma_blue_in;
         s1_gain_red_ff   <= s1_gain_red_in;
         s1_gain_green_ff <= s1_gain_green_in;
         s1_gain_blue_ff  <= s1_gain_blue_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: luma sum, gain shift and saturation at depth
   // ------------------------------------------------------------------------
   logic [LUMA_SUM_W-1:0] s2_luma_sum;
   logic [CHAN_W-1:0]     s2_luma_in;
   logic [CHAN_W-1:0]     s2_gain_red_in, s2_gain_green_in, s2_gain_blue_in;
   logic                  s2_load;
   req_data_type          s2_pix_ff;
   logic [CHAN_W-1:0]     s2_luma_ff;
   logic [CHAN_W-1:0]     s2_gain_red_ff, s2_gain_green_ff, s2_gain_blue_ff;

   function automatic logic [CHAN_W-1:0] gain_sat(input logic [PROD_W-1:0] prod,
                                                  input logic [CHAN_W-1:0] limit);
      logic [GAIN_SHIFT_W-1:0] scaled;
      scaled = prod[PROD_W-1:GAIN_FRAC_BITS];
      if (scaled > GAIN_SHIFT_W'(limit)) begin
         return limit;
      end
      return scaled[CHAN_W-1:0];
   endfunction

   // weights sum to one, so the luma always fits in a channel
   assign s2_luma_sum = LUMA_SUM_W'(s1_luma_red_ff) + LUMA_SUM_W'(s1_luma_green_ff)
                      + LUMA_SUM_W'(s1_luma_blue_ff);
   assign s2_luma_in  = s2_luma_sum[LUMA_FRAC_BITS +: CHAN_W];

   assign s2_gain_red_in   = gain_sat(s1_gain_red_ff,   depth_ff);
   assign s2_gain_green_in = gain_sat(s1_gain_green_ff, depth_ff);
   assign s2_gain_blue_in  = gain_sat(s1_gain_blue_ff,  depth_ff);

   assign s2_load = s1_valid_ff & s2_ready;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_pix_ff        <= s1_pix_ff;
         s2_luma_ff       <= s2_luma_in;
         s2_gain_red_ff   <= s2_gain_red_in;
         s2_gain_green_ff <= s2_gain_green_in;
         s2_gain_blue_ff  <= s2_gain_blue_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: invert and mode select into the output register
   // ------------------------------------------------------------------------
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;
   logic         s3_load;

   always_comb begin
      case (mode_ff)
         MODE_GRAY: begin
            rsp_data_in.red_out   = s2_luma_ff;
            rsp_data_in.green_out = s2_luma_ff;
            rsp_data_in.blue_out  = s2_luma_ff;
         end
         MODE_INVERT: begin
            // wraps when the channel is above depth
            rsp_data_in.red_out   = depth_ff - s2_pix_ff.red_in;
            rsp_data_in.green_out = depth_ff - s2_pix_ff.green_in;
            rsp_data_in.blue_out  = depth_ff - s2_pix_ff.blue_in;
         end
         MODE_GAIN: begin
            rsp_data_in.red_out   = s2_gain_red_ff;
            rsp_data_in.green_out = s2_gain_green_ff;
            rsp_data_in.blue_out  = s2_gain_blue_ff;
         end
         default: begin
            // unused mode passes the pixel through
            rsp_data_in.red_out   = s2_pix_ff.red_in;
            rsp_data_in.green_out = s2_pix_ff.green_in;
            rsp_data_in.blue_out  = s2_pix_ff.blue_in;
         end
      endcase
   end

   assign s3_load = s2_valid_ff & s3_ready;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/rpcf_checker.sv
// ----------------------------------------------------------------------------
// rpcf_checker
// port-level checks on the rgb pixel color filter, bound to the top level
// ----------------------------------------------------------------------------
module rpcf_checker
   import rpcf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data,
   input logic         pready
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // input is held back only while a result is blocked at the output
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked output");

   // an accepted pixel later shows as a valid output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##3 rsp_valid)
      else $error("no output three cycles after an input transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind rgb_pixel_color_filter rpcf_checker u_rpcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

>>> tb/sv/tb_rgb_pixel_color_filter.sv
// ----------------------------------------------------------------------------
// tb_rgb_pixel_color_filter
// self-checking bench for the rgb pixel color filter
// ----------------------------------------------------------------------------
// drives pixels on the req_ channel and predicts each filtered pixel from a
// local copy of the mode, depth and gain registers. a checker process compares
// every rsp_ transfer with the oldest prediction, field by field. registers go
// through the apb port only while no pixel is in flight, and every write to
// a mapped register is read back. directed tests cover the channel extremes,
// each filter mode, the pass-through code, depth zero, channels above depth,
// unmapped registers and one long output hold-off. random phases then change
// the whole register set and stream pixels, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_color_filter;
   import rpcf_pkg::*;

   localparam int CLOCK_HALF       = 10;
   localparam int RESET_CYCLES     = 11;
   localparam int IDLE_PERCENT     = 22;
   localparam int PHASE_COUNT      = 11;
   localparam int PIXELS_PER_PHASE = 150;
   localparam int HOLD_OFF_PIXELS  = 40;
   localparam int HOLD_OFF_CYCLES  = 80;
   localparam int DRAIN_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int NUM_REGS         = 5;

   // the mode code left unused by the filter passes pixels through
   localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;

   // bt.709 luma weights in q0.16 and the gain format of the predictor
   localparam int unsigned WEIGHT_RED   = 13933;
   localparam int unsigned WEIGHT_GREEN = 46871;
   localparam int unsigned WEIGHT_BLUE  = 4732;
   localparam int          LUMA_SHIFT   = 16;
   localparam int          GAIN_SHIFT   = 8;

   // dut ports, all inputs known from time zero
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_data_type        req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_data_type        rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [ADDR_W-1:0]   paddr     = '0;
   logic [DATA_W-1:0]   pwdata    = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // predictor copy of the register file
   logic [MODE_W-1:0]   mode_setting = MODE_GRAY;
   logic [CHAN_W-1:0]   depth_setting = 8'd255;
   logic [GAIN_W-1:0]   gain_setting [3] = '{16'd256, 16'd256, 16'd256};

   rsp_data_type        expected_pixels [$];
   int                  fail_count = 0;
   int                  cycle_count = 0;
   bit                  idle_enable = 1'b1;

   // output hold-off request, a toggle so that one process drives it
   logic                hold_off_toggle = 1'b0;
   logic                seen_toggle = 1'b0;
   int                  stall_left = 0;

   rgb_pixel_color_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // run limit, well above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // expected filtered pixel under the current register settings
   function automatic rsp_data_type filter_pixel(req_data_type px);
      logic [CHAN_W-1:0] chan [3];
      logic [CHAN_W-1:0] filtered [3];
      logic [31:0]       luma;
      logic [31:0]       scaled;
      rsp_data_type      result;
      chan[0] = px.red_in;
      chan[1] = px.green_in;
      chan[2] = px.blue_in;
      luma = (WEIGHT_RED * px.red_in + WEIGHT_GREEN * px.green_in
              + WEIGHT_BLUE * px.blue_in) >> LUMA_SHIFT;
      for (int i = 0; i < 3; i++) begin
         case (mode_setting)
            MODE_GRAY: begin
               // luma never exceeds full scale and ignores depth
               filtered[i] = luma[CHAN_W-1:0];
            end
            MODE_INVERT: begin
               // wraps modulo 256 when the channel lies above depth
               filtered[i] = depth_setting - chan[i];
            end
            MODE_GAIN: begin
               scaled = (32'(chan[i]) * 32'(gain_setting[i])) >> GAIN_SHIFT;
               filtered[i] = (scaled > 32'(depth_setting)) ? depth_setting
                                                            : scaled[CHAN_W-1:0];
            end
            default: begin
               filtered[i] = chan[i];
            end
         endcase
      end
      result.red_out   = filtered[0];
      result.green_out = filtered[1];
      result.blue_out  = filtered[2];
      return result;
   endfunction

   function automatic void apply_register(logic [REG_IDX_W-1:0] index,
                                          logic [DATA_W-1:0] value);
      case (index)
         REG_MODE:       mode_setting    = value[MODE_W-1:0];
         REG_DEPTH:      depth_setting   = value[CHAN_W-1:0];
         REG_GAIN_RED:   gain_setting[0] = value[GAIN_W-1:0];
         REG_GAIN_GREEN: gain_setting[1] = value[GAIN_W-1:0];
         REG_GAIN_BLUE:  gain_setting[2] = value[GAIN_W-1:0];
         default: ;  // no register there, the write goes nowhere
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] register_value(logic [REG_IDX_W-1:0] index);
      case (index)
         REG_MODE:       return DATA_W'(mode_setting);
         REG_DEPTH:      return DATA_W'(depth_setting);
         REG_GAIN_RED:   return DATA_W'(gain_setting[0]);
         REG_GAIN_GREEN: return DATA_W'(gain_setting[1]);
         REG_GAIN_BLUE:  return DATA_W'(gain_setting[2]);
         default:        return '0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // result side: random stall, long hold-off on request, checker
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_off_toggle != seen_toggle) begin
            seen_toggle = hold_off_toggle;
            stall_left  = HOLD_OFF_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   function automatic void compare_channel(string field, logic [CHAN_W-1:0] want,
                                           logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // each output transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel transfer with no pixel expected: %h", rsp_data);
            fail_count++;
         end else begin
            compare_channel("red_out", expected_pixels[0].red_out, rsp_data.red_out);
            compare_channel("green_out", expected_pixels[0].green_out,
                            rsp_data.green_out);
            compare_channel("blue_out", expected_pixels[0].blue_out,
                            rsp_data.blue_out);
            void'(expected_pixels.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------------
   // input side and register port
   // ------------------------------------------------------------------------

   // one pixel transfer, with random idle cycles ahead of it
   task automatic send_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                             logic [CHAN_W-1:0] blue);
      req_data_type px;
      px.red_in   = red;
      px.green_in = green;
      px.blue_in  = blue;
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      expected_pixels.push_back(filter_pixel(px));
   endtask

   // every pixel in flight has come out, so registers may change
   task automatic wait_pipeline_empty();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic check_register(logic [REG_IDX_W-1:0] index);
      logic [DATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'({index, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== register_value(index)) begin
         $error("register %0d: expected %h, actual %h", index, register_value(index), got);
         fail_count++;
      end
   endtask

   // setup and access cycle, then read back where a register exists
   task automatic write_register(logic [REG_IDX_W-1:0] index, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apply_register(index, value);
      if (index < NUM_REGS) check_register(index);
   endtask

   // ------------------------------------------------------------------------
   // random values
   // ------------------------------------------------------------------------

   // mostly uniform, with the edges around zero, full scale and depth
   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return depth_setting;
         3:       return depth_setting + 8'd1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_gain();
      case ($urandom_range(5))
         0:       return '0;
         1:       return DATA_W'(16'hffff);
         2:       return DATA_W'(16'd256);
         3:       return DATA_W'($urandom_range(512));
         default: return $urandom;  // upper bits are dropped by the register
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_depth();
      case ($urandom_range(4))
         0:       return '0;
         1:       return 32'd1;
         2:       return 32'd255;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset values read back, grayscale at the channel extremes
   task automatic test_reset_values();
      for (int i = 0; i < NUM_REGS; i++) check_register(REG_IDX_W'(i));
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      wait_pipeline_empty();
      // grayscale ignores a low depth
      write_register(REG_DEPTH, 32'd16);
      send_pixel(8'd200, 8'd200, 8'd200);
   endtask

   task automatic test_invert();
      wait_pipeline_empty();
      write_register(REG_MODE, DATA_W'(MODE_INVERT));
      write_register(REG_DEPTH, 32'd255);
      send_pixel(8'd0, 8'd255, 8'd128);
      wait_pipeline_empty();
      write_register(REG_DEPTH, 32'd0);
      send_pixel(8'd0, 8'd1, 8'd255);
      wait_pipeline_empty();
      // channel above depth wraps
      write_register(REG_DEPTH, 32'd100);
      send_pixel(8'd50, 8'd100, 8'd200);
   endtask

   task automatic test_gain();
      wait_pipeline_empty();
      write_register(REG_MODE, DATA_W'(MODE_GAIN));
      write_register(REG_DEPTH, 32'd255);
      send_pixel(8'd0, 8'd255, 8'd77);
      wait_pipeline_empty();
      write_register(REG_GAIN_RED, 32'd0);
      write_register(REG_GAIN_GREEN, 32'hffff_ffff);
      write_register(REG_GAIN_BLUE, 32'd384);
      send_pixel(8'd255, 8'd255, 8'd100);
      wait_pipeline_empty();
      // equal gains act as one scale factor
      for (int i = 0; i < 3; i++) write_register(REG_GAIN_RED + REG_IDX_W'(i), 32'd128);
      send_pixel(8'd200, 8'd201, 8'd1);
      wait_pipeline_empty();
      // depth zero saturates every channel to zero
      write_register(REG_DEPTH, 32'd0);
      send_pixel(8'd255, 8'd1, 8'd0);
      wait_pipeline_empty();
      write_register(REG_DEPTH, 32'd128);
      for (int i = 0; i < 3; i++) write_register(REG_GAIN_RED + REG_IDX_W'(i), 32'd512);
      send_pixel(8'd63, 8'd64, 8'd65);
   endtask

   task automatic test_pass_through();
      wait_pipeline_empty();
      // upper bits set as well, the register keeps only the mode bits
      write_register(REG_MODE, 32'hffff_fffc | DATA_W'(MODE_PASS));
      send_pixel(8'd1, 8'd2, 8'd3);
      send_pixel(8'd255, 8'd0, 8'd170);
   endtask

   // writes past the register list leave every register alone
   task automatic test_unmapped_registers();
      wait_pipeline_empty();
      for (int i = NUM_REGS; i < 2 ** REG_IDX_W; i++) begin
         write_register(REG_IDX_W'(i), 32'hffff_ffff);
      end
      for (int i = 0; i < NUM_REGS; i++) check_register(REG_IDX_W'(i));
      send_pixel(8'd90, 8'd180, 8'd45);
   endtask

   // the output holds off long enough for the pipeline to fill and stall input
   task automatic test_output_hold_off();
      wait_pipeline_empty();
      write_register(REG_MODE, DATA_W'(MODE_GAIN));
      write_register(REG_DEPTH, random_depth());
      idle_enable = 1'b0;
      hold_off_toggle <= ~hold_off_toggle;
      repeat (HOLD_OFF_PIXELS) send_pixel(random_channel(), random_channel(),
                                          random_channel());
      idle_enable = 1'b1;
   endtask

   // each phase sets all registers, then streams random pixels
   task automatic test_random_phases();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_pipeline_empty();
         // first phase runs with no idling at all
         idle_enable = (phase != 0);
         write_register(REG_MODE, ($urandom & ~32'h3) | DATA_W'(phase % 4));
         write_register(REG_DEPTH, random_depth());
         write_register(REG_GAIN_RED, random_gain());
         write_register(REG_GAIN_GREEN, random_gain());
         write_register(REG_GAIN_BLUE, random_gain());
         repeat (PIXELS_PER_PHASE) send_pixel(random_channel(), random_channel(),
                                              random_channel());
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_invert();
      test_gain();
      test_pass_through();
      test_unmapped_registers();
      test_output_hold_off();
      test_random_phases();
      wait_pipeline_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
